// ===== hw/rtl/hcbp_pkg.sv =====
// ---------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, request codes and the front-to-back queue entry type of
// the Huffman code bit packer.
// ---------------------------------------------------------------------------
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int VALUE_W = 32;
  localparam int LEN_W   = 6;
  localparam int SYMF_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int PAD_W   = 3;

  localparam int LEN_CAP = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W = LEN_W + VALUE_W;

  localparam int ACC_W = LEN_CAP + BYTE_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 2);

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic               flush;
    logic [VALUE_W-1:0] code;
    logic [LEN_W-1:0]   len;
  } q_entry_t;

endpackage

// ===== hw/rtl/hcbp_stream_if.sv =====
// ---------------------------------------------------------------------------
// hcbp_stream_if
// Valid/ready channels of the packer: request input and packed byte output.
// ---------------------------------------------------------------------------
interface hcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  symbol;
  logic [31:0] code_value;
  logic [5:0]  code_length;

  modport source (output valid, output req_type, output symbol, output code_value,
                  output code_length, input ready);
  modport sink   (input valid, input req_type, input symbol, input code_value,
                  input code_length, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] pad_bits;
  logic       is_final;
  logic       last_of_run;

  modport source (output valid, output out_byte, output pad_bits, output is_final,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input pad_bits, input is_final,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/hcbp_ram.sv =====
// ---------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/hcbp_front.sv =====
// ---------------------------------------------------------------------------
// hcbp_front
// Accept requests, keep the code table, look up codes and queue the encode
// and flush work for the packer.
// ---------------------------------------------------------------------------
module hcbp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  hcbp_in_if.sink                  in_ch,
  input  logic [hcbp_pkg::QC_W-1:0] q_count,
  output logic                     push,
  output hcbp_pkg::q_entry_t       push_entry
);
  import hcbp_pkg::*;

  logic               accept;
  logic               in_range;
  logic [SYM_W-1:0]   idx;
  logic [LEN_W-1:0]   len_sat;
  logic               we;
  logic               re;
  logic [ENTRY_W-1:0] rdata;
  logic [SYMBOL_COUNT-1:0] valid_r;
  logic               f1_valid_r;
  logic               f1_flush_r;
  logic [QC_W-1:0]    used;

  assign used        = QC_W'(q_count + QC_W'(f1_valid_r));
  assign in_ch.ready = used < QC_W'(Q_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_range = {1'b0, in_ch.symbol} < (SYMF_W + 1)'(SYMBOL_COUNT);
  assign idx      = in_ch.symbol[SYM_W-1:0];
  assign len_sat  = (in_ch.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                          : in_ch.code_length;

  assign we = accept && (in_ch.req_type == REQ_LOAD) && in_range;
  assign re = accept && (in_ch.req_type == REQ_ENCODE);

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata ({len_sat, in_ch.code_value}),
    .re    (re),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      f1_valid_r <= 1'b0;
      f1_flush_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[idx] <= 1'b1;
      end
      f1_valid_r <= accept && ((in_ch.req_type == REQ_FLUSH) ||
                               ((in_ch.req_type == REQ_ENCODE) && in_range &&
                                valid_r[idx]));
      f1_flush_r <= in_ch.req_type == REQ_FLUSH;
    end
  end

  // drop zero-length codes here
  assign push = f1_valid_r && (f1_flush_r || (rdata[ENTRY_W-1 -: LEN_W] != '0));

  always_comb begin
    push_entry.flush = f1_flush_r;
    push_entry.code  = rdata[VALUE_W-1:0];
    push_entry.len   = rdata[ENTRY_W-1 -: LEN_W];
  end

endmodule

// ===== hw/rtl/hcbp_queue.sv =====
// ---------------------------------------------------------------------------
// hcbp_queue
// Short FIFO of encode and flush work between the front and the packer.
// ---------------------------------------------------------------------------
module hcbp_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  hcbp_pkg::q_entry_t        push_entry,
  input  logic                      pop,
  output logic                      head_valid,
  output hcbp_pkg::q_entry_t        head,
  output logic [hcbp_pkg::QC_W-1:0] count
);
  import hcbp_pkg::*;

  q_entry_t          slot_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r;
  logic [QP_W-1:0]   rd_ptr_r;
  logic [QC_W-1:0]   count_r;
  logic [QC_W-1:0]   count_nxt;

  function automatic logic [QP_W-1:0] bump(input logic [QP_W-1:0] p);
    return (p == QP_W'(Q_DEPTH - 1)) ? '0 : QP_W'(p + 1'b1);
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = QC_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QC_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// ===== hw/rtl/hcbp_back.sv =====
// ---------------------------------------------------------------------------
// hcbp_back
// Bit packer: merge codes into a left-aligned accumulator, emit one byte per
// cycle into a free output register, pad and close the stream on flush.
// ---------------------------------------------------------------------------
module hcbp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hcbp_pkg::q_entry_t head,
  output logic               pop,
  hcbp_out_if.source         out_ch
);
  import hcbp_pkg::*;

  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [ACC_W-1:0]   acc_e;
  logic [CNT_W-1:0]   cnt_e;
  logic [VALUE_W-1:0] aligned;
  logic [ACC_W-1:0]   ext;
  logic               slot_free;
  logic               emit;
  logic               enc_take;
  logic               fl_take;
  logic               fl_res;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [PAD_W-1:0]   pad_r;
  logic               final_r;
  logic               last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = (cnt_r >= CNT_W'(BYTE_W)) && slot_free;
  assign acc_e     = emit ? (acc_r << BYTE_W) : acc_r;
  assign cnt_e     = emit ? CNT_W'(cnt_r - CNT_W'(BYTE_W)) : cnt_r;

  assign enc_take = head_valid && !head.flush && (cnt_e < CNT_W'(BYTE_W));
  assign fl_take  = head_valid && head.flush && (cnt_r < CNT_W'(BYTE_W)) &&
                    ((cnt_r == '0) || slot_free);
  assign fl_res   = fl_take && (cnt_r != '0);
  assign pop      = enc_take || fl_take;

  // left-align the code, first-sent bit on top
  assign aligned = head.code << (LEN_W'(VALUE_W) - head.len);
  assign ext     = {aligned[VALUE_W-1 -: LEN_CAP], {BYTE_W{1'b0}}};

  always_comb begin
    acc_nxt = acc_e;
    cnt_nxt = cnt_e;
    if (enc_take) begin
      acc_nxt = acc_e | (ext >> cnt_e);
      cnt_nxt = CNT_W'(cnt_e + CNT_W'(head.len));
    end else if (fl_take) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit || fl_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= acc_r[ACC_W-1 -: BYTE_W];
      pad_r      <= '0;
      final_r    <= 1'b0;
      last_r     <= cnt_r < CNT_W'(2 * BYTE_W);
    end else if (fl_res) begin
      out_byte_r <= acc_r[ACC_W-1 -: BYTE_W];
      pad_r      <= PAD_W'(CNT_W'(BYTE_W) - cnt_r);
      final_r    <= 1'b1;
      last_r     <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.pad_bits    = pad_r;
  assign out_ch.is_final    = final_r;
  assign out_ch.last_of_run = last_r;

endmodule

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// ---------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman code table plus MSB-first byte packer with flush and padding.
//
//   channel  dir  payload                                        transfer
//   in_ch    in   req_type, symbol, code_value, code_length     valid & ready
//   out_ch   out  out_byte, pad_bits, is_final, last_of_run      valid & ready
//
// One request per cycle is taken while the work queue has room; a code's
// table entry comes out of the RAM in the cycle after its request is taken.
// The packer emits one byte per cycle while its output register is free, and
// takes the next code only once under a byte is left; flush sends the padded tail.
// Reset clears the table valid bits at once, no clearing pass is needed.
// Output stalls back up through the packer and the 4-entry queue to in_ch.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  logic       clk,
  input  logic       rst_n,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);
  import hcbp_pkg::*;

  logic            push;
  q_entry_t        push_entry;
  logic            pop;
  logic            head_valid;
  q_entry_t        head;
  logic [QC_W-1:0] q_count;

  hcbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  hcbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  hcbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== test/tb_huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_huffman_code_bit_packer
// Streams code table loads, byte encodes, flushes and unused requests into
// the packer with random source gaps and sink stalls, predicts every packed
// byte it must produce and checks each output transfer, in order.
// ---------------------------------------------------------------------------
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_REQS   = 384;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sym;
    logic [31:0] value;
    logic [5:0]  length;
    logic [7:0]  idle_after;
    logic        drain;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] pad;
    logic       fin;
    logic       last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  hcbp_in_if  in_if ();
  hcbp_out_if out_if ();

  huffman_code_bit_packer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t         req_q [$];
  packed_byte_t want_q [$];
  req_t         cur_req;
  packed_byte_t rx_want;

  logic [31:0] code_tbl [SYMBOL_COUNT];
  logic [5:0]  len_tbl  [SYMBOL_COUNT];
  logic [7:0]  acc_byte;
  int          acc_fill;

  bit          gen_loaded [256];
  logic [7:0]  gen_syms [$];

  int total_reqs;
  int sent_cnt = 0;
  int out_cnt = 0;
  int err_cnt = 0;
  int idle_cycles;
  int tx_wait;
  int rx_stall;
  int rx_phase = 0;
  bit rx_calm = 1'b0;

  // Expected bytes of one accepted request
  task automatic pack_request(input req_t rq);
    logic [5:0]   ln;
    logic [31:0]  cv;
    logic [7:0]   done [4];
    packed_byte_t pb;
    int           n;
    int           k;
    n = 0;
    case (rq.kind)
      REQ_LOAD: begin
        if (int'(rq.sym) < SYMBOL_COUNT) begin
          ln = (int'(rq.length) > LEN_CAP) ? 6'(LEN_CAP) : rq.length;
          code_tbl[rq.sym] = rq.value;
          len_tbl[rq.sym]  = ln;
        end
      end
      REQ_ENCODE: begin
        if (int'(rq.sym) < SYMBOL_COUNT) begin
          ln = len_tbl[rq.sym];
          cv = code_tbl[rq.sym];
          for (k = int'(ln) - 1; k >= 0; k--) begin
            acc_byte[7 - acc_fill] = cv[k];
            acc_fill++;
            if (acc_fill == 8) begin
              done[n] = acc_byte;
              n++;
              acc_byte = '0;
              acc_fill = 0;
            end
          end
          for (k = 0; k < n; k++) begin
            pb.data = done[k];
            pb.pad  = 3'd0;
            pb.fin  = 1'b0;
            pb.last = (k == n - 1);
            want_q.push_back(pb);
          end
        end
      end
      REQ_FLUSH: begin
        if (acc_fill != 0) begin
          pb.data = acc_byte;
          pb.pad  = 3'(8 - acc_fill);
          pb.fin  = 1'b1;
          pb.last = 1'b1;
          want_q.push_back(pb);
          acc_byte = '0;
          acc_fill = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at byte %0d: %s got 0x%0h want 0x%0h", out_cnt, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [7:0] gap_pick(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 8'd0;
    if (r < 88) return 8'($urandom_range(1, 3));
    if (r < 97) return 8'($urandom_range(4, 12));
    return 8'($urandom_range(20, 60));
  endfunction

  function automatic logic [5:0] len_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 6'd0;
    if (r < 60) return 6'($urandom_range(1, 8));
    if (r < 85) return 6'($urandom_range(9, 20));
    if (r < 95) return 6'($urandom_range(21, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  task automatic add_req(input logic [1:0] kind, input logic [7:0] sym,
                         input logic [31:0] value, input logic [5:0] length,
                         input bit calm, input bit drain);
    req_t rq;
    rq.kind       = kind;
    rq.sym        = sym;
    rq.value      = value;
    rq.length     = length;
    rq.idle_after = gap_pick(calm);
    rq.drain      = drain;
    if (kind == REQ_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      gen_syms.push_back(sym);
    end
    req_q.push_back(rq);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pack_request(cur_req);
        sent_cnt++;
        tx_wait = int'(cur_req.idle_after);
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the stalled transfer
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_if.valid <= 1'b0;
      end else if (req_q.size() == 0 || (req_q[0].drain && want_q.size() != 0)) begin
        in_if.valid <= 1'b0;
      end else begin
        cur_req = req_q.pop_front();
        in_if.req_type    <= cur_req.kind;
        in_if.symbol      <= cur_req.sym;
        in_if.code_value  <= cur_req.value;
        in_if.code_length <= cur_req.length;
        in_if.valid       <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (want_q.size() == 0) begin
          report("out_byte with nothing pending", 32'(out_if.out_byte), 32'd0);
        end else begin
          rx_want = want_q.pop_front();
          if (out_if.out_byte !== rx_want.data) begin
            report("out_byte", 32'(out_if.out_byte), 32'(rx_want.data));
          end
          if (out_if.pad_bits !== rx_want.pad) begin
            report("pad_bits", 32'(out_if.pad_bits), 32'(rx_want.pad));
          end
          if (out_if.is_final !== rx_want.fin) begin
            report("is_final", 32'(out_if.is_final), 32'(rx_want.fin));
          end
          if (out_if.last_of_run !== rx_want.last) begin
            report("last_of_run", 32'(out_if.last_of_run), 32'(rx_want.last));
          end
        end
        out_cnt++;
      end
      rx_phase++;
      if (rx_phase == 150) begin
        rx_phase = 0;
        rx_calm  = ($urandom_range(0, 2) == 0);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        rx_stall = int'(gap_pick(rx_calm));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         i;
    int         r;
    int         left;
    bit         calm;
    logic [7:0] s;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.req_type    = REQ_LOAD;
    in_if.symbol      = '0;
    in_if.code_value  = '0;
    in_if.code_length = '0;
    out_if.ready      = 1'b0;
    for (i = 0; i < SYMBOL_COUNT; i++) len_tbl[i] = '0;
    for (i = 0; i < 256; i++) gen_loaded[i] = 1'b0;
    acc_byte = '0;
    acc_fill = 0;

    add_req(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h80, 32'hFFFF_FFFF, 6'h3F, 1'b0, 1'b0);
    add_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0);
    add_req(REQ_LOAD,   8'hFF, 32'h0000_0000, 6'd1,  1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h01, 32'hFFFF_FFF5, 6'd3,  1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h02, 32'hA5A5_5A5A, 6'd63, 1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h03, 32'hDEAD_BEEF, 6'd0,  1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h04, 32'h0000_00C3, 6'd8,  1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h05, 32'h1234_5678, 6'd33, 1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_UNUSED, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_LOAD,   8'h80, 32'h0000_007F, 6'd7,  1'b0, 1'b0);
    add_req(REQ_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 1'b0);
    add_req(REQ_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1);

    left = 0;
    calm = 1'b0;
    for (i = 0; i < RAND_REQS; i++) begin
      if (left == 0) begin
        left = $urandom_range(15, 40);
        calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      r = $urandom_range(0, 99);
      if (gen_syms.size() < 4 || r < 14) begin
        add_req(REQ_LOAD, 8'($urandom_range(0, 255)), $urandom, len_pick(), calm,
                $urandom_range(0, 49) == 0);
      end else if (r < 84) begin
        if ($urandom_range(0, 9) == 0) s = 8'($urandom_range(0, 255));
        else s = gen_syms[$urandom_range(0, gen_syms.size() - 1)];
        add_req(REQ_ENCODE, s, $urandom, 6'($urandom_range(0, 63)), calm,
                $urandom_range(0, 49) == 0);
      end else if (r < 94) begin
        add_req(REQ_FLUSH, 8'($urandom_range(0, 255)), $urandom, 6'($urandom_range(0, 63)),
                calm, $urandom_range(0, 49) == 0);
      end else begin
        add_req(REQ_UNUSED, 8'($urandom_range(0, 255)), $urandom, 6'($urandom_range(0, 63)),
                calm, 1'b0);
      end
    end
    add_req(REQ_FLUSH, 8'h00, 32'h0000_0000, 6'd0, 1'b0, 1'b0);
    total_reqs = req_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt < total_reqs || want_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
